/* rtl/core/cfua_pkg.sv */
// ---------------------------------------------------------------------------
// cfua_pkg
// shared types and constants of the cheapest free unit task allocator
// ---------------------------------------------------------------------------
package cfua_pkg;

	localparam int COST_W = 20;
	localparam int TIME_W = 32;
	localparam int BUSY_W = 33;
	localparam int PROD_W = 52;
	localparam int SUM_W  = 63;
	localparam int UIU_W  = 5;
	localparam int UIDX_W = 4;

	localparam logic [UIU_W-1:0] UNITS_IN_USE_RST = UIU_W'(16);
	localparam logic [SUM_W-1:0] SUM_MAX           = {SUM_W{1'b1}};

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TASK = 1'b1;

	typedef struct packed {
		logic              op;
		logic [UIDX_W-1:0] unit_index;
		logic [COST_W-1:0] unit_cost;
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] run_length;
	} task_t;

	typedef struct packed {
		logic              accepted;
		logic [UIDX_W-1:0] chosen_unit;
		logic [PROD_W-1:0] energy_added;
		logic [SUM_W-1:0]  total_energy;
	} res_t;

	// scan unit status towards the sequencer
	typedef struct packed {
		logic done;
		logic found;
	} scan_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_ACC
	} state_t;

endpackage

/* rtl/core/cfua_ram.sv */
// ---------------------------------------------------------------------------
// cfua_ram
// generic single write port ram with a registered read port
// ---------------------------------------------------------------------------
module cfua_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/cfua_scan.sv */
// ---------------------------------------------------------------------------
// cfua_scan
// walks the unit tables one entry a cycle and keeps the cheapest free unit
// ---------------------------------------------------------------------------
module cfua_scan #(
	parameter int NUM_UNITS = 16
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 start,
	input  logic [$clog2(NUM_UNITS+1)-1:0]                       limit,
	input  logic [cfua_pkg::TIME_W-1:0]                          arrival,
	output logic                                                 rd_en,
	output logic [((NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1)-1:0] rd_addr,
	input  logic [cfua_pkg::COST_W-1:0]                          rd_cost,
	input  logic [cfua_pkg::BUSY_W-1:0]                          rd_busy,
	output cfua_pkg::scan_res_t                                  res,
	output logic [((NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1)-1:0] best_idx,
	output logic [cfua_pkg::COST_W-1:0]                          best_cost
);
	import cfua_pkg::*;

	localparam int AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
	localparam int CW = $clog2(NUM_UNITS+1);

	logic          running_q;
	logic [CW-1:0] issue_cnt_q;
	logic          pend_s1;
	logic [AW-1:0] pidx_s1;
	logic          found_q;
	logic [AW-1:0] best_q;
	logic [COST_W-1:0] best_cost_q;
	logic          is_free;
	logic          take;

	assign rd_en     = running_q && (issue_cnt_q < limit);
	assign rd_addr   = issue_cnt_q[AW-1:0];
	assign is_free   = rd_busy <= {1'b0, arrival};
	// strict compare keeps the lowest index on equal cost
	assign take      = pend_s1 && is_free && (!found_q || (rd_cost < best_cost_q));
	assign res.done  = running_q && !rd_en && !pend_s1;
	assign res.found = found_q;
	assign best_idx  = best_q;
	assign best_cost = best_cost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			issue_cnt_q <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
		end else if (start) begin
			running_q   <= 1'b1;
			issue_cnt_q <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			if (rd_en) begin
				issue_cnt_q <= issue_cnt_q + CW'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (res.done) begin
				running_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pidx_s1 <= rd_addr;
		end
		if (take) begin
			best_q      <= pidx_s1;
			best_cost_q <= rd_cost;
		end
	end

endmodule

/* rtl/core/cheapest_free_unit_task_allocator_top.sv */
// ---------------------------------------------------------------------------
// cheapest_free_unit_task_allocator_top
// assigns each task to the cheapest free unit and keeps a saturating energy total
// ---------------------------------------------------------------------------
// latency, from the accepting edge to the edge that registers the result:
//   a load at the accepting edge itself; a task scans L = min(units_in_use,
//   NUM_UNITS) entries one a cycle, then multiplies and accumulates, or drops
// throughput: one transaction at a time; the next is taken once the result
//   has left the output register
// reset: arst_n frees all units at cost zero, clears the total, units_in_use 16
module cheapest_free_unit_task_allocator_top #(
	parameter int NUM_UNITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [cfua_pkg::UIU_W-1:0]   cfg_wr_data,
	input  logic                         task_valid,
	output logic                         task_stall,
	input  cfua_pkg::task_t              task_data,
	output logic                         res_valid,
	input  logic                         res_stall,
	output cfua_pkg::res_t               res_data
);
	import cfua_pkg::*;

	localparam int AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
	localparam int CW = $clog2(NUM_UNITS+1);

	// configuration and sequencing
	logic [UIU_W-1:0]  units_q;
	state_t            state_q, state_nxt;
	logic              task_acc;
	logic [CW-1:0]     limit;

	// per-item registers
	logic [TIME_W-1:0] arrive_q;
	logic [TIME_W-1:0] len_q;
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W:0]    sum_wide;

	// table storage: valid bits stand in for the zero reset of the rams
	logic [NUM_UNITS-1:0] cost_vld_q;
	logic [NUM_UNITS-1:0] busy_vld_q;
	logic                 cost_vld_s1;
	logic                 busy_vld_s1;
	logic [COST_W-1:0]    cost_rd;
	logic [BUSY_W-1:0]    busy_rd;
	logic                 load_in_range;

	// scan unit
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	scan_res_t         scan;
	logic [AW-1:0]     best_idx;
	logic [COST_W-1:0] best_cost;

	// decoded actions from the sequencer
	logic scan_start;
	logic cost_we;
	logic busy_we;
	logic out_load;
	logic out_drop;
	logic out_task;

	// output register
	logic res_valid_q;
	res_t res_q;

	assign task_stall = (state_q != ST_IDLE) || res_valid_q;
	assign task_acc   = task_valid && !task_stall;
	assign res_valid  = res_valid_q;
	assign res_data   = res_q;

	// units_in_use above the table size counts as the table size
	assign limit = (9'(units_q) > 9'(NUM_UNITS)) ? CW'(NUM_UNITS) : CW'(units_q);

	assign load_in_range = 9'(task_data.unit_index) < 9'(NUM_UNITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_q <= UNITS_IN_USE_RST;
		end else if (cfg_wr_en) begin
			units_q <= cfg_wr_data;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (task_acc && (task_data.op == OP_TASK)) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan.done) begin
					state_nxt = scan.found ? ST_MUL : ST_IDLE;
				end
			end
			ST_MUL:  state_nxt = ST_ACC;
			ST_ACC:  state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		scan_start = 1'b0;
		cost_we    = 1'b0;
		busy_we    = 1'b0;
		out_load   = 1'b0;
		out_drop   = 1'b0;
		out_task   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (task_acc) begin
					if (task_data.op == OP_TASK) begin
						scan_start = 1'b1;
					end else begin
						cost_we  = load_in_range;
						out_load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (scan.done) begin
					busy_we  = scan.found;
					out_drop = !scan.found;
				end
			end
			ST_MUL:  ;
			ST_ACC:  out_task = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// cost table: written by loads only while idle, read only while scanning
	cfua_ram #(
		.WIDTH (COST_W),
		.DEPTH (NUM_UNITS)
	) u_cost_ram (
		.clk   (clk),
		.we    (cost_we),
		.waddr (AW'(task_data.unit_index)),
		.wdata (task_data.unit_cost),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (cost_rd)
	);

	// busy-until table: written once the scan has finished, so no overlap
	cfua_ram #(
		.WIDTH (BUSY_W),
		.DEPTH (NUM_UNITS)
	) u_busy_ram (
		.clk   (clk),
		.we    (busy_we),
		.waddr (best_idx),
		.wdata ({1'b0, arrive_q} + {1'b0, len_q}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (busy_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_vld_q  <= '0;
			busy_vld_q  <= '0;
			cost_vld_s1 <= 1'b0;
			busy_vld_s1 <= 1'b0;
		end else begin
			if (cost_we) begin
				cost_vld_q[AW'(task_data.unit_index)] <= 1'b1;
			end
			if (busy_we) begin
				busy_vld_q[best_idx] <= 1'b1;
			end
			if (rd_en) begin
				cost_vld_s1 <= cost_vld_q[rd_addr];
				busy_vld_s1 <= busy_vld_q[rd_addr];
			end
		end
	end

	cfua_scan #(
		.NUM_UNITS (NUM_UNITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.limit     (limit),
		.arrival   (arrive_q),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_cost   (cost_vld_s1 ? cost_rd : '0),
		.rd_busy   (busy_vld_s1 ? busy_rd : '0),
		.res       (scan),
		.best_idx  (best_idx),
		.best_cost (best_cost)
	);

	// task operands held for the whole transaction
	always_ff @(posedge clk) begin
		if (scan_start) begin
			arrive_q <= task_data.arrival_time;
			len_q    <= task_data.run_length;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(best_cost * len_q);
		end
	end

	// saturating total: the carry out of bit 62 means past the maximum
	assign sum_wide = {1'b0, sum_q} + (SUM_W+1)'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (out_task) begin
			sum_q <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
		end
	end

	// result register, freed when the downstream side takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load || out_drop || out_task) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load || out_drop) begin
			res_q.accepted     <= 1'b0;
			res_q.chosen_unit  <= '0;
			res_q.energy_added <= '0;
			res_q.total_energy <= sum_q;
		end else if (out_task) begin
			res_q.accepted     <= 1'b1;
			res_q.chosen_unit  <= UIDX_W'(best_idx);
			res_q.energy_added <= prod_q;
			res_q.total_energy <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
		end
	end

endmodule

/* rtl/core/cfua_checker.sv */
// ---------------------------------------------------------------------------
// cfua_checker
// port-level checks on the allocator, bound to the top level
// ---------------------------------------------------------------------------
module cfua_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             task_valid,
	input logic             task_stall,
	input cfua_pkg::task_t  task_data,
	input logic             res_valid,
	input logic             res_stall,
	input cfua_pkg::res_t   res_data
);
	import cfua_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	// a stalled input transaction holds
	a_task_hold: assert property (@(posedge clk) disable iff (!arst_n)
		task_valid && task_stall |=> task_valid && $stable(task_data))
		else $error("stalled input changed");

	// no new transaction while a result waits
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> task_stall)
		else $error("task accepted while a result waits");

	// after a transaction is taken the block is busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		task_valid && !task_stall |=> task_stall)
		else $error("input free right after acceptance");

	// a load or dropped task charges nothing
	a_no_charge: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.accepted |->
			(res_data.chosen_unit == '0) && (res_data.energy_added == '0))
		else $error("unassigned result carries a charge");

endmodule

bind cheapest_free_unit_task_allocator_top cfua_checker u_cfua_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.task_valid (task_valid),
	.task_stall (task_stall),
	.task_data  (task_data),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_data   (res_data)
);
